// File: rtl/core/htpp_pkg.sv
// shared types and constants of the pseudo-random probe hash table
`default_nettype none

package htpp_pkg;

	// fixed field widths
	localparam int REQ_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int REF_W   = 10;
	localparam int STAT_W  = 3;
	localparam int PCNT_W  = 6;

	// probe step is (key mod STEP_MOD) + 1
	localparam int STEP_MOD = 10;
	localparam int STEP_W   = 4;

	// largest reportable probe count
	localparam logic [PCNT_W-1:0] PCNT_MAX = 6'd63;

	// request codes
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd0;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd1;
	localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd2;
	localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
	localparam logic [STAT_W-1:0] STAT_CLEARED   = 3'd4;

	// controller states
	typedef enum logic [2:0] {
		CTL_INIT,
		CTL_IDLE,
		CTL_MOD,
		CTL_READ,
		CTL_CHECK,
		CTL_SWEEP
	} ctl_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic              accept;
		logic              mod_step;
		logic              probe_start;
		logic              probe_next;
		logic              ins_write;
		logic              sweep_step;
		logic              emit;
		logic [STAT_W-1:0] res_status;
	} htpp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic mod_done;
		logic sweep_done;
		logic slot_empty;
		logic key_match;
		logic walk_done;
		logic out_free;
	} htpp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/htpp_in_if.sv
// request channel carrying name bytes and operation codes
`default_nettype none

interface htpp_in_if
	import htpp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [CHAR_W-1:0] name_char;
	logic              name_last;
	logic [REF_W-1:0]  record_ref;

	modport source (output valid, req_type, name_char, name_last, record_ref, input ready);
	modport sink   (input valid, req_type, name_char, name_last, record_ref, output ready);
endinterface

`default_nettype wire

// File: rtl/core/htpp_out_if.sv
// result channel carrying status, reference and probe count
`default_nettype none

interface htpp_out_if
	import htpp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [REF_W-1:0]  found_ref;
	logic [PCNT_W-1:0] probe_count;

	modport source (output valid, status, found_ref, probe_count, input ready);
	modport sink   (input valid, status, found_ref, probe_count, output ready);
endinterface

`default_nettype wire

// File: rtl/core/htpp_ctrl.sv
// controller state machine sequencing division, probing and clearing
`default_nettype none

module htpp_ctrl
	import htpp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [REQ_W-1:0] req_type,
	input  wire logic             name_last,
	input  wire htpp_stat_t       stat,
	output logic                  in_ready,
	output htpp_cmd_t             cmd
);

	ctl_state_t       state_q, state_d;
	logic [REQ_W-1:0] op_q;
	logic             start_op;

	// state and latched operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_INIT;
			op_q    <= REQ_INSERT;
		end else begin
			state_q <= state_d;
			if (start_op) begin
				op_q <= req_type;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		start_op = 1'b0;
		unique case (state_q)
			CTL_INIT: begin
				cmd.sweep_step = 1'b1;
				if (stat.sweep_done) begin
					state_d = CTL_IDLE;
				end
			end
			CTL_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && name_last) begin
					start_op = 1'b1;
					priority case (req_type)
						REQ_INSERT, REQ_LOOKUP: state_d = CTL_MOD;
						REQ_CLEAR:              state_d = CTL_SWEEP;
						default:                state_d = CTL_IDLE;
					endcase
				end
			end
			CTL_MOD: begin
				if (stat.mod_done) begin
					cmd.probe_start = 1'b1;
					state_d         = CTL_READ;
				end else begin
					cmd.mod_step = 1'b1;
				end
			end
			CTL_READ: begin
				state_d = CTL_CHECK;
			end
			CTL_CHECK: begin
				if (op_q == REQ_INSERT) begin
					// insert stops at the first free slot or once every slot has been probed
					if (stat.slot_empty) begin
						if (stat.out_free) begin
							cmd.ins_write  = 1'b1;
							cmd.emit       = 1'b1;
							cmd.res_status = STAT_INSERTED;
							state_d        = CTL_IDLE;
						end
					end else if (stat.walk_done) begin
						if (stat.out_free) begin
							cmd.emit       = 1'b1;
							cmd.res_status = STAT_FULL;
							state_d        = CTL_IDLE;
						end
					end else begin
						cmd.probe_next = 1'b1;
						state_d        = CTL_READ;
					end
				end else begin
					// lookup stops at an empty slot, a matching key or once every slot has been probed
					if (stat.slot_empty) begin
						if (stat.out_free) begin
							cmd.emit       = 1'b1;
							cmd.res_status = STAT_NOT_FOUND;
							state_d        = CTL_IDLE;
						end
					end else if (stat.key_match) begin
						if (stat.out_free) begin
							cmd.emit       = 1'b1;
							cmd.res_status = STAT_FOUND;
							state_d        = CTL_IDLE;
						end
					end else if (stat.walk_done) begin
						if (stat.out_free) begin
							cmd.emit       = 1'b1;
							cmd.res_status = STAT_NOT_FOUND;
							state_d        = CTL_IDLE;
						end
					end else begin
						cmd.probe_next = 1'b1;
						state_d        = CTL_READ;
					end
				end
			end
			CTL_SWEEP: begin
				if (!stat.sweep_done) begin
					cmd.sweep_step = 1'b1;
				end else if (stat.out_free) begin
					cmd.sweep_step = 1'b1;
					cmd.emit       = 1'b1;
					cmd.res_status = STAT_CLEARED;
					state_d        = CTL_IDLE;
				end
			end
			default: begin
				state_d = CTL_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/htpp_dpath.sv
// datapath: key sum, modulo unit, slot memory, probe walk and result register
`default_nettype none

module htpp_dpath
	import htpp_pkg::*;
#(
	parameter int TABLE_SLOTS  = 47,
	parameter int RECORD_COUNT = 1024,
	parameter int KEY_BITS     = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire htpp_cmd_t         cmd,
	input  wire logic [CHAR_W-1:0] name_char,
	input  wire logic              name_last,
	input  wire logic [REF_W-1:0]  record_ref,
	input  wire logic              out_ready,
	output htpp_stat_t             stat,
	output logic                   out_valid,
	output logic [STAT_W-1:0]      status,
	output logic [REF_W-1:0]       found_ref,
	output logic [PCNT_W-1:0]      probe_count
);

	localparam int IDX_W  = $clog2(TABLE_SLOTS);
	localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
	localparam int WORD_W = 1 + KEY_BITS + REF_W;
	localparam int REF_CAP = RECORD_COUNT - 1;
	localparam logic [REF_W-1:0] REF_SAT = REF_W'(REF_CAP);

	// rounded-up reciprocals, exact quotients for every key
	localparam int MUL_W  = KEY_BITS + 1;
	localparam int PROD_W = KEY_BITS + MUL_W;
	localparam int SH_S   = KEY_BITS + IDX_W;
	localparam int SH_T   = KEY_BITS + STEP_W;
	localparam logic [63:0] RCP_S =
		((64'd1 << SH_S) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
	localparam logic [63:0] RCP_T =
		((64'd1 << SH_T) + 64'(STEP_MOD) - 64'd1) / 64'(STEP_MOD);
	localparam logic [MUL_W-1:0] MUL_S = MUL_W'(RCP_S);
	localparam logic [MUL_W-1:0] MUL_T = MUL_W'(RCP_T);

	// phases of the remainder unit
	localparam logic [1:0] MOD_MUL  = 2'd0;
	localparam logic [1:0] MOD_DONE = 2'd2;

	logic [KEY_BITS-1:0] key_sum_q, key_next, key_q;
	logic [REF_W-1:0]    ref_q, ref_sat;
	logic [IDX_W-1:0]    rem_s_q, pos_q, sweep_q, pos_adv;
	logic [IDX_W:0]      pos_sum;
	logic [STEP_W-1:0]   rem_t_q, step_q;
	logic [1:0]          mod_cnt_q;
	logic [PROD_W-1:0]   prod_s_q, prod_t_q;
	logic [KEY_BITS-1:0] quo_s, quo_t, rem_s_full, rem_t_full;
	logic [CNT_W-1:0]    n_q;
	logic [WORD_W-1:0]   slot_mem_q [TABLE_SLOTS];
	logic [WORD_W-1:0]   rd_q;
	logic                rd_valid;
	logic [KEY_BITS-1:0] rd_key;
	logic [REF_W-1:0]    rd_rec;
	logic                out_valid_q;
	logic [STAT_W-1:0]   status_q;
	logic [REF_W-1:0]    found_ref_q;
	logic [PCNT_W-1:0]   probe_count_q, n_sat;

	// next key sum and saturated reference
	assign key_next = key_sum_q + KEY_BITS'(name_char);
	assign ref_sat  = ({7'd0, record_ref} > 17'(REF_CAP)) ? REF_SAT : record_ref;

	// remainders from the registered reciprocal products
	assign quo_s      = KEY_BITS'(prod_s_q >> SH_S);
	assign quo_t      = KEY_BITS'(prod_t_q >> SH_T);
	assign rem_s_full = key_q - quo_s * KEY_BITS'(TABLE_SLOTS);
	assign rem_t_full = key_q - quo_t * KEY_BITS'(STEP_MOD);

	// next probe position, wrapping around the table
	assign pos_sum = {1'b0, pos_q} + (IDX_W+1)'(step_q);
	assign pos_adv = (pos_sum >= (IDX_W+1)'(TABLE_SLOTS)) ?
		IDX_W'(pos_sum - (IDX_W+1)'(TABLE_SLOTS)) : IDX_W'(pos_sum);

	// key accumulation, division and walk control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_sum_q <= '0;
			mod_cnt_q <= '0;
			sweep_q   <= '0;
			n_q       <= '0;
		end else begin
			if (cmd.accept) begin
				key_sum_q <= name_last ? '0 : key_next;
				if (name_last) begin
					mod_cnt_q <= MOD_MUL;
				end
			end else if (cmd.mod_step) begin
				mod_cnt_q <= mod_cnt_q + 1'b1;
			end
			if (cmd.sweep_step) begin
				sweep_q <= stat.sweep_done ? '0 : sweep_q + 1'b1;
			end
			if (cmd.probe_start) begin
				n_q <= CNT_W'(1);
			end else if (cmd.probe_next) begin
				n_q <= n_q + 1'b1;
			end
		end
	end

	// payload registers of the operation
	always_ff @(posedge clk) begin
		if (cmd.accept && name_last) begin
			key_q <= key_next;
			ref_q <= ref_sat;
		end else if (cmd.mod_step) begin
			if (mod_cnt_q == MOD_MUL) begin
				prod_s_q <= PROD_W'(key_q) * PROD_W'(MUL_S);
				prod_t_q <= PROD_W'(key_q) * PROD_W'(MUL_T);
			end else begin
				rem_s_q <= IDX_W'(rem_s_full);
				rem_t_q <= STEP_W'(rem_t_full);
			end
		end
		if (cmd.probe_start) begin
			pos_q  <= rem_s_q;
			step_q <= rem_t_q + 1'b1;
		end else if (cmd.probe_next) begin
			pos_q <= pos_adv;
		end
	end

	// slot memory, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.ins_write) begin
			slot_mem_q[pos_q] <= {1'b1, key_q, ref_q};
		end else if (cmd.sweep_step) begin
			slot_mem_q[sweep_q] <= '0;
		end
		rd_q <= slot_mem_q[pos_q];
	end

	assign rd_valid = rd_q[WORD_W-1];
	assign rd_key   = rd_q[KEY_BITS+REF_W-1:REF_W];
	assign rd_rec   = rd_q[REF_W-1:0];

	// status towards the controller
	always_comb begin
		stat.mod_done   = (mod_cnt_q == MOD_DONE);
		stat.sweep_done = (sweep_q == IDX_W'(TABLE_SLOTS - 1));
		stat.slot_empty = !rd_valid;
		stat.key_match  = rd_valid && (rd_key == key_q);
		stat.walk_done  = (n_q == CNT_W'(TABLE_SLOTS));
		stat.out_free   = !out_valid_q || out_ready;
	end

	assign n_sat = (32'(n_q) > 32'(PCNT_MAX)) ? PCNT_MAX : PCNT_W'(n_q);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q <= cmd.res_status;
			if (cmd.res_status == STAT_FOUND) begin
				found_ref_q <= rd_rec;
			end else if (cmd.res_status == STAT_INSERTED) begin
				found_ref_q <= ref_q;
			end else begin
				found_ref_q <= '0;
			end
			probe_count_q <= (cmd.res_status == STAT_CLEARED) ? '0 : n_sat;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_ref   = found_ref_q;
	assign probe_count = probe_count_q;

endmodule

`default_nettype wire

// File: rtl/core/hash_table_pseudo_random_probe_top.sv
// top level of the open-addressing hash table with pseudo-random probing
//
// req_ch takes one name byte per transaction; bytes are summed into a key.
// On the byte marked name_last the request runs: insert, lookup or clear.
// A non-final byte is accepted in the idle state and gives no result.
// Insert and lookup first reduce the key modulo the slot count and modulo
// ten by reciprocal multiplication, then walk the slot memory: each slot
// gets a registered read, then a compare. req_ch is not ready until the
// result transaction is offered on res_ch. Clear sweeps the slot memory
// one entry per cycle, the last entry once res_ch is free. After reset
// the same sweep runs while req_ch is held not ready; the key sum starts
// at zero. Results sit in an output register; bytes keep being taken while
// it waits, but a finished operation holds in place until res_ch is free,
// so a stalled receiver stalls the next request.
`default_nettype none

module hash_table_pseudo_random_probe_top
	import htpp_pkg::*;
#(
	parameter int TABLE_SLOTS  = 47,
	parameter int RECORD_COUNT = 1024,
	parameter int KEY_BITS     = 16
) (
	input wire logic    clk,
	input wire logic    arst_n,
	htpp_in_if.sink     req_ch,
	htpp_out_if.source  res_ch
);

	htpp_cmd_t  cmd;
	htpp_stat_t stat;
	logic       in_ready;

	// sequencing
	htpp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_ch.valid),
		.req_type  (req_ch.req_type),
		.name_last (req_ch.name_last),
		.stat      (stat),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	// storage and arithmetic
	htpp_dpath #(
		.TABLE_SLOTS  (TABLE_SLOTS),
		.RECORD_COUNT (RECORD_COUNT),
		.KEY_BITS     (KEY_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.name_char   (req_ch.name_char),
		.name_last   (req_ch.name_last),
		.record_ref  (req_ch.record_ref),
		.out_ready   (res_ch.ready),
		.stat        (stat),
		.out_valid   (res_ch.valid),
		.status      (res_ch.status),
		.found_ref   (res_ch.found_ref),
		.probe_count (res_ch.probe_count)
	);

	assign req_ch.ready = in_ready;

endmodule

`default_nettype wire
